// ===== hw/rtl/udpfb_pkg.sv =====
package udpfb_pkg;

    localparam int HEADER_BYTES = 42;
    localparam int IP_HDR_LEN   = 20;
    localparam int UDP_HDR_LEN  = 8;
    localparam int HDR_IDX_W    = 6;

    localparam logic [7:0]  ETHERTYPE_HI = 8'h08;
    localparam logic [7:0]  ETHERTYPE_LO = 8'h00;
    localparam logic [7:0]  IP_VER_IHL   = 8'h45;
    localparam logic [7:0]  IP_TTL       = 8'd64;
    localparam logic [7:0]  IP_PROTO_UDP = 8'd17;

    localparam int CSUM_STEPS = 10;
    localparam int STEP_W     = 4;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_FETCH = 1'b1;

    typedef struct packed {
        logic [31:0] source_ip;
        logic [31:0] dest_ip;
        logic [15:0] source_port;
        logic [15:0] dest_port;
        logic [15:0] ip_len;
        logic [15:0] udp_len;
        logic [15:0] payload_sum;
    } csum_in_t;

    typedef struct packed {
        logic [47:0] dest_mac;
        logic [47:0] source_mac;
        logic [31:0] source_ip;
        logic [31:0] dest_ip;
        logic [15:0] source_port;
        logic [15:0] dest_port;
        logic [15:0] ip_len;
        logic [15:0] udp_len;
        logic [15:0] ip_csum;
        logic [15:0] udp_csum;
    } hdr_fields_t;

    function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

endpackage

// ===== hw/rtl/udp_ipv4_frame_builder_unit.sv =====
// Builds an Ethernet/IPv4/UDP frame from loaded payload bytes. A load item (tuser low)
// stores one payload byte in the payload RAM; loads beyond MAX_PAYLOAD bytes
// are dropped and flagged on every byte of that frame, and loads during readout are ignored.
// A fetch item (tuser high) returns the next frame byte. A fetch registers the payload RAM
// read, then loads the byte into the output register once that is free; the first fetch of
// a frame latches the addresses, ports and destination MAC and waits in ST_CSUM while both
// checksums are accumulated one 16-bit word per cycle over ten steps. The payload RAM needs
// no clearing pass after reset. The source MAC is read live from its register on every fetch.
module udp_ipv4_frame_builder_unit #(
    parameter int MAX_PAYLOAD = 1024
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [47:0]  cfg_wdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // payload_byte, source_ip, dest_ip, source_port, dest_port, dest_mac
    input  logic [151:0] s_axis_tdata,
    // opcode
    input  logic         s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // frame_byte
    output logic [7:0]   m_axis_tdata,
    output logic         m_axis_tlast,
    // payload_dropped
    output logic         m_axis_tuser
);
    import udpfb_pkg::*;

    localparam int ADDR_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int CNT_W  = $clog2(MAX_PAYLOAD + 1);
    localparam int POS_W  = $clog2(HEADER_BYTES + MAX_PAYLOAD);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CSUM = 2'd1;
    localparam logic [1:0] ST_OUT  = 2'd2;

    logic [1:0]       state_reg;
    logic [1:0]       state_next;
    logic [47:0]      source_mac_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [15:0]      sum_reg;
    logic [15:0]      sum_next;
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic             dropped_reg;
    logic             dropped_next;
    logic [31:0]      sip_reg;
    logic [31:0]      dip_reg;
    logic [15:0]      sport_reg;
    logic [15:0]      dport_reg;
    logic [47:0]      dmac_reg;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [7:0]       out_byte_reg;
    logic             out_last_reg;
    logic             out_dropped_reg;

    logic             in_accept;
    logic             is_fetch;
    logic             first_fetch;
    logic             load_ok;
    logic             full;
    logic             ram_we;
    logic [7:0]       in_byte;
    logic [15:0]      in_word;
    logic [POS_W-1:0] payload_off;
    logic [7:0]       ram_rd_data;
    logic             csum_done;
    logic [15:0]      ip_csum;
    logic [15:0]      udp_csum;
    logic [15:0]      ip_len;
    logic [15:0]      udp_len;
    csum_in_t         csum_in;
    hdr_fields_t      hdr_fields;
    logic [7:0]       hdr_byte;
    logic [7:0]       frame_byte;
    logic [POS_W:0]   frame_len;
    logic [POS_W:0]   pos_plus;
    logic             is_last;
    logic             out_load;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign is_fetch      = (s_axis_tuser == OP_FETCH);
    assign first_fetch   = in_accept && is_fetch && (pos_reg == '0);
    assign load_ok       = in_accept && !is_fetch && (pos_reg == '0);
    assign full          = (count_reg == CNT_W'(MAX_PAYLOAD));
    assign ram_we        = load_ok && !full;
    assign in_byte       = s_axis_tdata[7:0];
    assign in_word       = count_reg[0] ? {8'd0, in_byte} : {in_byte, 8'd0};
    assign payload_off   = pos_reg - POS_W'(HEADER_BYTES);

    assign ip_len  = 16'(count_reg) + 16'(IP_HDR_LEN + UDP_HDR_LEN);
    assign udp_len = 16'(count_reg) + 16'(UDP_HDR_LEN);

    udpfb_ram #(
        .WIDTH (8),
        .DEPTH (MAX_PAYLOAD)
    ) u_payload_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (count_reg[ADDR_W-1:0]),
        .wr_data (in_byte),
        .rd_en   (in_accept && is_fetch),
        .rd_addr (payload_off[ADDR_W-1:0]),
        .rd_data (ram_rd_data)
    );

    always_comb
    begin
        csum_in.source_ip   = sip_reg;
        csum_in.dest_ip     = dip_reg;
        csum_in.source_port = sport_reg;
        csum_in.dest_port   = dport_reg;
        csum_in.ip_len      = ip_len;
        csum_in.udp_len     = udp_len;
        csum_in.payload_sum = sum_reg;
    end

    udpfb_csum u_csum (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (first_fetch),
        .csum_in  (csum_in),
        .done     (csum_done),
        .ip_csum  (ip_csum),
        .udp_csum (udp_csum)
    );

    always_comb
    begin
        hdr_fields.dest_mac    = dmac_reg;
        hdr_fields.source_mac  = source_mac_reg;
        hdr_fields.source_ip   = sip_reg;
        hdr_fields.dest_ip     = dip_reg;
        hdr_fields.source_port = sport_reg;
        hdr_fields.dest_port   = dport_reg;
        hdr_fields.ip_len      = ip_len;
        hdr_fields.udp_len     = udp_len;
        hdr_fields.ip_csum     = ip_csum;
        hdr_fields.udp_csum    = udp_csum;
    end

    udpfb_hdr u_hdr (
        .idx      (pos_reg[HDR_IDX_W-1:0]),
        .fields   (hdr_fields),
        .hdr_byte (hdr_byte)
    );

    assign frame_byte = (pos_reg >= POS_W'(HEADER_BYTES)) ? ram_rd_data : hdr_byte;
    assign frame_len  = (POS_W+1)'(HEADER_BYTES) + (POS_W+1)'(count_reg);
    assign pos_plus   = {1'b0, pos_reg} + (POS_W+1)'(1);
    assign is_last    = (pos_plus >= frame_len);
    assign out_load   = (state_reg == ST_OUT) && (!out_valid_reg || m_axis_tready);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        sum_next       = sum_reg;
        pos_next       = pos_reg;
        dropped_next   = dropped_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        case (state_reg)
            ST_IDLE:
            begin
                if (load_ok)
                begin
                    if (full)
                    begin
                        dropped_next = 1'b1;
                    end
                    else
                    begin
                        count_next = count_reg + CNT_W'(1);
                        sum_next   = oc_add(sum_reg, in_word);
                    end
                end
                if (in_accept && is_fetch)
                begin
                    state_next = first_fetch ? ST_CSUM : ST_OUT;
                end
            end
            ST_CSUM:
            begin
                if (csum_done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                    if (is_last)
                    begin
                        count_next   = '0;
                        sum_next     = 16'd0;
                        pos_next     = '0;
                        dropped_next = 1'b0;
                    end
                    else
                    begin
                        pos_next = pos_reg + POS_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            source_mac_reg <= 48'd0;
            count_reg      <= '0;
            sum_reg        <= 16'd0;
            pos_reg        <= '0;
            dropped_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            sum_reg       <= sum_next;
            pos_reg       <= pos_next;
            dropped_reg   <= dropped_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                source_mac_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (first_fetch)
        begin
            sip_reg   <= s_axis_tdata[39:8];
            dip_reg   <= s_axis_tdata[71:40];
            sport_reg <= s_axis_tdata[87:72];
            dport_reg <= s_axis_tdata[103:88];
            dmac_reg  <= s_axis_tdata[151:104];
        end
        if (out_load)
        begin
            out_byte_reg    <= frame_byte;
            out_last_reg    <= is_last;
            out_dropped_reg <= dropped_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_byte_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_dropped_reg;

endmodule

// ===== hw/rtl/udpfb_ram.sv =====
module udpfb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/udpfb_csum.sv =====
module udpfb_csum (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  udpfb_pkg::csum_in_t csum_in,
    output logic               done,
    output logic [15:0]        ip_csum,
    output logic [15:0]        udp_csum
);
    import udpfb_pkg::*;

    logic              busy_reg;
    logic              busy_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic [15:0]       ip_acc_reg;
    logic [15:0]       ip_acc_next;
    logic [15:0]       udp_acc_reg;
    logic [15:0]       udp_acc_next;
    logic [15:0]       ip_word;
    logic [15:0]       udp_word;
    logic              last_step;
    logic [15:0]       udp_inv;

    // The address words are shared by both sums; the rest differ per header.
    always_comb
    begin
        ip_word  = 16'd0;
        udp_word = 16'd0;
        case (step_reg)
            4'd0:
            begin
                ip_word  = csum_in.source_ip[31:16];
                udp_word = csum_in.source_ip[31:16];
            end
            4'd1:
            begin
                ip_word  = csum_in.source_ip[15:0];
                udp_word = csum_in.source_ip[15:0];
            end
            4'd2:
            begin
                ip_word  = csum_in.dest_ip[31:16];
                udp_word = csum_in.dest_ip[31:16];
            end
            4'd3:
            begin
                ip_word  = csum_in.dest_ip[15:0];
                udp_word = csum_in.dest_ip[15:0];
            end
            4'd4:
            begin
                ip_word  = {IP_VER_IHL, 8'd0};
                udp_word = {8'd0, IP_PROTO_UDP};
            end
            4'd5:
            begin
                ip_word  = csum_in.ip_len;
                udp_word = csum_in.udp_len;
            end
            4'd6:
            begin
                ip_word  = {IP_TTL, IP_PROTO_UDP};
                udp_word = csum_in.udp_len;
            end
            4'd7:
            begin
                udp_word = csum_in.source_port;
            end
            4'd8:
            begin
                udp_word = csum_in.dest_port;
            end
            4'd9:
            begin
                udp_word = csum_in.payload_sum;
            end
            default:
            begin
                ip_word  = 16'd0;
                udp_word = 16'd0;
            end
        endcase
    end

    assign last_step = (step_reg == STEP_W'(CSUM_STEPS - 1));

    always_comb
    begin
        busy_next    = busy_reg;
        step_next    = step_reg;
        ip_acc_next  = ip_acc_reg;
        udp_acc_next = udp_acc_reg;
        if (start)
        begin
            busy_next    = 1'b1;
            step_next    = '0;
            ip_acc_next  = 16'd0;
            udp_acc_next = 16'd0;
        end
        else if (busy_reg)
        begin
            ip_acc_next  = oc_add(ip_acc_reg, ip_word);
            udp_acc_next = oc_add(udp_acc_reg, udp_word);
            step_next    = step_reg + STEP_W'(1);
            if (last_step)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            step_reg    <= '0;
            ip_acc_reg  <= 16'd0;
            udp_acc_reg <= 16'd0;
        end
        else
        begin
            busy_reg    <= busy_next;
            step_reg    <= step_next;
            ip_acc_reg  <= ip_acc_next;
            udp_acc_reg <= udp_acc_next;
        end
    end

    assign done     = busy_reg && last_step;
    assign ip_csum  = ~ip_acc_reg;
    assign udp_inv  = ~udp_acc_reg;
    assign udp_csum = (udp_inv == 16'd0) ? 16'hFFFF : udp_inv;

endmodule

// ===== hw/rtl/udpfb_hdr.sv =====
module udpfb_hdr (
    input  logic [udpfb_pkg::HDR_IDX_W-1:0] idx,
    input  udpfb_pkg::hdr_fields_t          fields,
    output logic [7:0]                      hdr_byte
);
    import udpfb_pkg::*;

    always_comb
    begin
        case (idx)
            6'd0:  hdr_byte = fields.dest_mac[47:40];
            6'd1:  hdr_byte = fields.dest_mac[39:32];
            6'd2:  hdr_byte = fields.dest_mac[31:24];
            6'd3:  hdr_byte = fields.dest_mac[23:16];
            6'd4:  hdr_byte = fields.dest_mac[15:8];
            6'd5:  hdr_byte = fields.dest_mac[7:0];
            6'd6:  hdr_byte = fields.source_mac[47:40];
            6'd7:  hdr_byte = fields.source_mac[39:32];
            6'd8:  hdr_byte = fields.source_mac[31:24];
            6'd9:  hdr_byte = fields.source_mac[23:16];
            6'd10: hdr_byte = fields.source_mac[15:8];
            6'd11: hdr_byte = fields.source_mac[7:0];
            6'd12: hdr_byte = ETHERTYPE_HI;
            6'd13: hdr_byte = ETHERTYPE_LO;
            6'd14: hdr_byte = IP_VER_IHL;
            6'd16: hdr_byte = fields.ip_len[15:8];
            6'd17: hdr_byte = fields.ip_len[7:0];
            6'd22: hdr_byte = IP_TTL;
            6'd23: hdr_byte = IP_PROTO_UDP;
            6'd24: hdr_byte = fields.ip_csum[15:8];
            6'd25: hdr_byte = fields.ip_csum[7:0];
            6'd26: hdr_byte = fields.source_ip[31:24];
            6'd27: hdr_byte = fields.source_ip[23:16];
            6'd28: hdr_byte = fields.source_ip[15:8];
            6'd29: hdr_byte = fields.source_ip[7:0];
            6'd30: hdr_byte = fields.dest_ip[31:24];
            6'd31: hdr_byte = fields.dest_ip[23:16];
            6'd32: hdr_byte = fields.dest_ip[15:8];
            6'd33: hdr_byte = fields.dest_ip[7:0];
            6'd34: hdr_byte = fields.source_port[15:8];
            6'd35: hdr_byte = fields.source_port[7:0];
            6'd36: hdr_byte = fields.dest_port[15:8];
            6'd37: hdr_byte = fields.dest_port[7:0];
            6'd38: hdr_byte = fields.udp_len[15:8];
            6'd39: hdr_byte = fields.udp_len[7:0];
            6'd40: hdr_byte = fields.udp_csum[15:8];
            6'd41: hdr_byte = fields.udp_csum[7:0];
            default: hdr_byte = 8'd0;
        endcase
    end

endmodule

// ===== hw/rtl/udpfb_checker.sv =====
module udpfb_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tlast,
    input logic       m_axis_tuser
);
    import udpfb_pkg::*;

    logic        out_accept;
    logic [10:0] byte_cnt_reg;
    logic        in_frame_reg;
    logic        dropped_reg;

    assign out_accept = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_cnt_reg <= 11'd0;
            in_frame_reg <= 1'b0;
            dropped_reg  <= 1'b0;
        end
        else if (out_accept)
        begin
            byte_cnt_reg <= m_axis_tlast ? 11'd0 : byte_cnt_reg + 11'd1;
            in_frame_reg <= !m_axis_tlast;
            dropped_reg  <= m_axis_tuser;
        end
    end

    // A frame is never shorter than its headers.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_accept && m_axis_tlast |-> byte_cnt_reg >= 11'(HEADER_BYTES - 1))
        else $error("frame ended inside the header");

    // Loads are ignored during readout, so the drop flag holds over a frame.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_accept && in_frame_reg |-> m_axis_tuser == dropped_reg)
        else $error("drop flag changed within a frame");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_accept && byte_cnt_reg == 11'd12 |-> m_axis_tdata == ETHERTYPE_HI)
        else $error("wrong ethertype byte");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_accept && byte_cnt_reg == 11'd14 |-> m_axis_tdata == IP_VER_IHL)
        else $error("wrong IP version byte");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output item changed while stalled");

endmodule

bind udp_ipv4_frame_builder_unit udpfb_checker u_checker (.*);
